// ===== rtl/core/swse_pkg.sv =====
// Shared types, widths and register codes for the sliding-window slope estimator.
// Used by the top level, the port checker and the testbench files.
`default_nettype none

package swse_pkg;

    // Default history depth for the sample ring.
    localparam int HISTORY_DEPTH_DEF = 64;

    // Field widths of the channels.
    localparam int TEMP_W  = 12;
    localparam int ENTRY_W = 2 * TEMP_W;
    localparam int WIN_W   = 7;
    localparam int LIM_W   = 16;
    localparam int SPM_W   = 16;
    localparam int RATE_W  = 32;

    // Accumulator widths, sized for windows of up to 127 samples.
    localparam int X_W   = 7;
    localparam int SQ_W  = 14;
    localparam int SX_W  = 13;
    localparam int SXX_W = 20;
    localparam int SY_W  = 19;
    localparam int SXY_W = 26;
    localparam int NUM_W = 34;
    localparam int DEN_W = 28;

    // Shared multiplier operand and product widths.
    localparam int MA_W = 34;
    localparam int MB_W = 17;
    localparam int MP_W = MA_W + MB_W;

    // Divider widths: dividend is |num| * spm * 16, divisor is the positive denominator.
    localparam int SCALE_SH = 4;
    localparam int DIVN_W   = 52;
    localparam int DIVD_W   = 27;

    // Saturation limits of a rate.
    localparam logic [RATE_W-1:0] RATE_MAX = 32'h7FFF_FFFF;
    localparam logic [RATE_W-1:0] RATE_MIN = 32'h8000_0000;

    // APB port geometry and register indexes.
    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;
    localparam int REGIX_W = 3;

    typedef enum logic [REGIX_W-1:0] {
        REG_COLD_WINDOW = 3'd0,
        REG_HOT_WINDOW  = 3'd1,
        REG_STABLE_MIN  = 3'd2,
        REG_STABLE_LIM  = 3'd3,
        REG_SPM         = 3'd4
    } swse_reg_t;

    // Reset values of the configuration registers.
    localparam logic [WIN_W-1:0] COLD_WINDOW_RST = 7'd30;
    localparam logic [WIN_W-1:0] HOT_WINDOW_RST  = 7'd60;
    localparam logic [WIN_W-1:0] STABLE_MIN_RST  = 7'd60;
    localparam logic [LIM_W-1:0] STABLE_LIM_RST  = 16'd256;
    localparam logic [SPM_W-1:0] SPM_RST         = 16'd60;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_WALK,
        ST_NUM_A,
        ST_NUM_B,
        ST_DEN_A,
        ST_DEN_B,
        ST_DEN_C,
        ST_SCALE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_OUT
    } swse_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/swse_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; holds the sample ring of the slope estimator.
`default_nettype none

module swse_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write and one registered read per cycle.
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/swse_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on swse_pkg only through the widths handed down by the top level.
`default_nettype none

module swse_div #(
    parameter int NW = 52,
    parameter int DW = 27
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] dividend,
    input  wire logic [DW-1:0] divisor,
    output logic               done,
    output logic      [NW-1:0] quotient
);

    localparam int CNT_W = $clog2(NW + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NW-1:0]    quo_reg, quo_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    dsr_reg, dsr_next;
    logic [DW:0]      trial;
    logic             fits;

    // Shift in the next dividend bit and subtract when the divisor fits.
    always_comb begin
        trial     = {rem_reg, quo_reg[NW-1]};
        fits      = trial >= {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NW);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? DW'(trial - {1'b0, dsr_reg}) : trial[DW-1:0];
            quo_next = {quo_reg[NW-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk) begin
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sliding_window_slope_estimator.sv =====
// Top level of the sliding-window least-squares slope estimator.
// Depends on swse_pkg, swse_ram (sample ring) and swse_div (rate divider).
//
//   Channel   Direction  Handshake           Beat contents
//   s_        in         s_valid / s_ready   cold and hot plate temperature
//   m_        out        m_valid / m_ready   cold/hot rates, valid bits, stable flag
//   APB       config     psel/penable        five registers at 4*i, pready tied high
//
// A side whose window exceeds the history skips the walk and the divider; a window
// of 0 or 1 is walked but skips the divider. The walk reads one ring entry per cycle
// and the divider yields one quotient bit per cycle; these two take up most of a beat.
// s_ready is high only in the idle state.
// Reset is synchronous, active low; the ring itself is not cleared.
// A finished result waits in the output register while the next beat is taken in.
`default_nettype none

module sliding_window_slope_estimator #(
    parameter int HISTORY_DEPTH = swse_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Sample channel
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [swse_pkg::TEMP_W-1:0]  s_cold_temp,
    input  wire logic signed [swse_pkg::TEMP_W-1:0]  s_hot_temp,
    // Result channel
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed      [swse_pkg::RATE_W-1:0]  m_cold_rate,
    output logic                                     m_cold_rate_valid,
    output logic signed      [swse_pkg::RATE_W-1:0]  m_hot_rate,
    output logic                                     m_hot_rate_valid,
    output logic                                     m_hot_stable,
    // Configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic        [swse_pkg::APB_AW-1:0]  paddr,
    input  wire logic        [swse_pkg::APB_DW-1:0]  pwdata,
    output logic             [swse_pkg::APB_DW-1:0]  prdata,
    output logic                                     pready
);

    import swse_pkg::*;

    localparam int AW   = $clog2(HISTORY_DEPTH);
    localparam int CW   = $clog2(HISTORY_DEPTH + 1);
    localparam int CMPW = (CW > WIN_W) ? CW : WIN_W;
    localparam int PW   = ((AW + 1) > WIN_W) ? (AW + 1) : WIN_W;

    // Configuration registers
    logic [WIN_W-1:0] cold_window_reg, hot_window_reg, stable_min_reg;
    logic [LIM_W-1:0] stable_lim_reg;
    logic [SPM_W-1:0] spm_reg;
    logic             cfg_wr;
    swse_reg_t        cfg_ix;

    // Sequencer and ring control
    swse_state_t      state_reg, state_next;
    logic             side_reg, side_next;
    logic [AW-1:0]    wp_reg, wp_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             v1_reg, v1_next;
    logic             v2_reg, v2_next;
    logic             m_valid_reg, m_valid_next;

    // Walk and arithmetic registers
    logic        [WIN_W-1:0]  win_reg, win_next;
    logic        [X_W-1:0]    idx_reg, idx_next;
    logic        [X_W-1:0]    x1_reg, x1_next;
    logic        [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic        [SQ_W-1:0]   sq_reg, sq_next;
    logic        [SX_W-1:0]   sx_reg, sx_next;
    logic        [SXX_W-1:0]  sxx_reg, sxx_next;
    logic signed [SY_W-1:0]   sy_reg, sy_next;
    logic signed [SXY_W-1:0]  sxy_reg, sxy_next;
    logic signed [NUM_W-1:0]  acc_reg, acc_next;
    logic signed [NUM_W-1:0]  num_reg, num_next;
    logic signed [DEN_W-1:0]  den_reg, den_next;
    logic signed [MP_W-1:0]   prod_reg;

    // Per-item results
    logic [RATE_W-1:0] cold_rate_reg, hot_rate_reg;
    logic              cold_ok_reg, hot_ok_reg;

    // Output registers
    logic [RATE_W-1:0] m_cold_rate_reg, m_hot_rate_reg;
    logic              m_cold_ok_reg, m_hot_ok_reg, m_stable_reg;

    // Combinational helpers
    logic                     accept;
    logic [WIN_W-1:0]         win_sel;
    logic                     win_fits;
    logic [PW-1:0]            start_raw, start_adj;
    logic                     issue;
    logic signed [TEMP_W-1:0] y_val;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic                     mul_en;
    logic signed [NUM_W-1:0]  mag;
    logic                     den_pos;
    logic                     side_done;
    logic                     ok_wr, ok_val;
    logic                     rate_wr;
    logic [RATE_W-1:0]        rate_val;
    logic                     q_big;
    logic                     out_load;
    logic [RATE_W:0]          hot_ext, hot_abs;
    logic                     stable;
    logic                     div_start, div_done;
    logic [DIVN_W-1:0]        div_quo;
    logic [ENTRY_W-1:0]       rd_data;

    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);

    // Configuration writes and reads.
    assign cfg_wr = psel && penable && pwrite;
    assign cfg_ix = swse_reg_t'(paddr[APB_AW-1:2]);
    assign pready = 1'b1;

    always_comb begin
        case (cfg_ix)
            REG_COLD_WINDOW: prdata = APB_DW'(cold_window_reg);
            REG_HOT_WINDOW:  prdata = APB_DW'(hot_window_reg);
            REG_STABLE_MIN:  prdata = APB_DW'(stable_min_reg);
            REG_STABLE_LIM:  prdata = APB_DW'(stable_lim_reg);
            REG_SPM:         prdata = APB_DW'(spm_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cold_window_reg <= COLD_WINDOW_RST;
            hot_window_reg  <= HOT_WINDOW_RST;
            stable_min_reg  <= STABLE_MIN_RST;
            stable_lim_reg  <= STABLE_LIM_RST;
            spm_reg         <= SPM_RST;
        end else if (cfg_wr) begin
            case (cfg_ix)
                REG_COLD_WINDOW: cold_window_reg <= pwdata[WIN_W-1:0];
                REG_HOT_WINDOW:  hot_window_reg  <= pwdata[WIN_W-1:0];
                REG_STABLE_MIN:  stable_min_reg  <= pwdata[WIN_W-1:0];
                REG_STABLE_LIM:  stable_lim_reg  <= pwdata[LIM_W-1:0];
                REG_SPM:         spm_reg         <= pwdata[SPM_W-1:0];
                default: ;
            endcase
        end
    end

    // Sample ring: written on each accepted beat, read during the walk.
    swse_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ram (
        .clk   (aclk),
        .we    (accept),
        .waddr (wp_reg),
        .wdata ({s_hot_temp, s_cold_temp}),
        .re    (issue),
        .raddr (rd_ptr_reg),
        .rdata (rd_data)
    );

    // Window setup: validity against the history and the oldest slot of the window.
    always_comb begin
        win_sel   = side_reg ? hot_window_reg : cold_window_reg;
        win_fits  = CMPW'(win_sel) <= CMPW'(count_reg);
        start_raw = PW'(wp_reg) + PW'(HISTORY_DEPTH) - PW'(win_sel);
        start_adj = (start_raw >= PW'(HISTORY_DEPTH)) ?
                    (start_raw - PW'(HISTORY_DEPTH)) : start_raw;
    end

    assign issue   = (state_reg == ST_WALK) && (idx_reg < win_reg);
    assign y_val   = side_reg ? rd_data[ENTRY_W-1:TEMP_W] : rd_data[TEMP_W-1:0];
    assign mag     = num_reg[NUM_W-1] ? -num_reg : num_reg;
    assign den_pos = !den_reg[DEN_W-1] && (den_reg != '0);

    // Saturate the divider quotient to a signed 32-bit rate.
    always_comb begin
        q_big = |div_quo[DIVN_W-1:RATE_W-1];
        if (num_reg[NUM_W-1]) begin
            rate_val = q_big ? RATE_MIN : -div_quo[RATE_W-1:0];
        end else begin
            rate_val = q_big ? RATE_MAX : div_quo[RATE_W-1:0];
        end
    end

    // Hot-side stability from the finished hot rate.
    always_comb begin
        hot_ext = (RATE_W + 1)'($signed(hot_rate_reg));
        hot_abs = hot_rate_reg[RATE_W-1] ? -hot_ext : hot_ext;
        stable  = (CMPW'(count_reg) >= CMPW'(stable_min_reg)) && hot_ok_reg &&
                  (hot_abs <= (RATE_W + 1)'(stable_lim_reg));
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                if (!win_fits) begin
                    state_next = side_reg ? ST_OUT : ST_SETUP;
                end else begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (!issue && !v1_reg && !v2_reg) begin
                    state_next = ST_NUM_A;
                end
            end
            ST_NUM_A: state_next = ST_NUM_B;
            ST_NUM_B: state_next = ST_DEN_A;
            ST_DEN_A: state_next = ST_DEN_B;
            ST_DEN_B: state_next = ST_DEN_C;
            ST_DEN_C: state_next = ST_SCALE;
            ST_SCALE: begin
                if (!den_pos) begin
                    state_next = side_reg ? ST_OUT : ST_SETUP;
                end else begin
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = side_reg ? ST_OUT : ST_SETUP;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath control and register next values for each state.
    always_comb begin
        side_done   = 1'b0;
        ok_wr       = 1'b0;
        ok_val      = 1'b0;
        rate_wr     = 1'b0;
        out_load    = 1'b0;
        div_start   = 1'b0;
        mul_en      = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        v1_next     = 1'b0;
        v2_next     = 1'b0;
        wp_next     = wp_reg;
        count_next  = count_reg;
        win_next    = win_reg;
        idx_next    = idx_reg;
        x1_next     = x1_reg;
        rd_ptr_next = rd_ptr_reg;
        sq_next     = sq_reg;
        sx_next     = sx_reg;
        sxx_next    = sxx_reg;
        sy_next     = sy_reg;
        sxy_next    = sxy_reg;
        acc_next    = acc_reg;
        num_next    = num_reg;
        den_next    = den_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    wp_next = (wp_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                    if (count_reg != CW'(HISTORY_DEPTH)) begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            ST_SETUP: begin
                win_next    = win_sel;
                idx_next    = '0;
                rd_ptr_next = start_adj[AW-1:0];
                sq_next     = '0;
                sx_next     = '0;
                sxx_next    = '0;
                sy_next     = '0;
                sxy_next    = '0;
                ok_wr       = 1'b1;
                ok_val      = win_fits;
                side_done   = !win_fits;
            end
            ST_WALK: begin
                // Issue stage: address the next entry and advance the abscissa sums.
                if (issue) begin
                    rd_ptr_next = (rd_ptr_reg == AW'(HISTORY_DEPTH - 1)) ?
                                  '0 : rd_ptr_reg + 1'b1;
                    idx_next    = idx_reg + 1'b1;
                    sx_next     = sx_reg + SX_W'(idx_reg);
                    sxx_next    = sxx_reg + SXX_W'(sq_reg);
                    sq_next     = sq_reg + SQ_W'({idx_reg, 1'b1});
                    x1_next     = idx_reg;
                    v1_next     = 1'b1;
                end
                // Data stage: sum y and form x*y in the shared multiplier.
                if (v1_reg) begin
                    sy_next = sy_reg + SY_W'(y_val);
                    mul_a   = MA_W'(y_val);
                    mul_b   = MB_W'(x1_reg);
                    mul_en  = 1'b1;
                    v2_next = 1'b1;
                end
                // Accumulate stage.
                if (v2_reg) begin
                    sxy_next = sxy_reg + SXY_W'(prod_reg);
                end
            end
            ST_NUM_A: begin
                mul_a  = MA_W'(sxy_reg);
                mul_b  = MB_W'(win_reg);
                mul_en = 1'b1;
            end
            ST_NUM_B: begin
                acc_next = NUM_W'(prod_reg);
                mul_a    = MA_W'(sy_reg);
                mul_b    = MB_W'(sx_reg);
                mul_en   = 1'b1;
            end
            ST_DEN_A: begin
                num_next = acc_reg - NUM_W'(prod_reg);
                mul_a    = MA_W'(sxx_reg);
                mul_b    = MB_W'(win_reg);
                mul_en   = 1'b1;
            end
            ST_DEN_B: begin
                acc_next = NUM_W'(prod_reg);
                mul_a    = MA_W'(sx_reg);
                mul_b    = MB_W'(sx_reg);
                mul_en   = 1'b1;
            end
            ST_DEN_C: begin
                den_next = DEN_W'(acc_reg - NUM_W'(prod_reg));
            end
            ST_SCALE: begin
                // A window of at most one sample has no spread: its rate is zero.
                if (!den_pos) begin
                    rate_wr   = 1'b1;
                    side_done = 1'b1;
                end else begin
                    mul_a  = mag;
                    mul_b  = MB_W'(spm_reg);
                    mul_en = 1'b1;
                end
            end
            ST_DIV_GO: begin
                div_start = 1'b1;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    rate_wr   = 1'b1;
                    side_done = 1'b1;
                end
            end
            ST_OUT: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: ;
        endcase

        side_next    = side_done ? !side_reg : side_reg;
        m_valid_next = out_load || (m_valid_reg && !m_ready);
    end

    // Quotient of the scaled numerator over the denominator.
    swse_div #(
        .NW (DIVN_W),
        .DW (DIVD_W)
    ) u_div (
        .clk      (aclk),
        .rst_n    (aresetn),
        .start    (div_start),
        .dividend ({prod_reg[DIVN_W-SCALE_SH-1:0], {SCALE_SH{1'b0}}}),
        .divisor  (den_reg[DIVD_W-1:0]),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Control state with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            side_reg    <= 1'b0;
            wp_reg      <= '0;
            count_reg   <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            side_reg    <= side_next;
            wp_reg      <= wp_next;
            count_reg   <= count_next;
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        win_reg    <= win_next;
        idx_reg    <= idx_next;
        x1_reg     <= x1_next;
        rd_ptr_reg <= rd_ptr_next;
        sq_reg     <= sq_next;
        sx_reg     <= sx_next;
        sxx_reg    <= sxx_next;
        sy_reg     <= sy_next;
        sxy_reg    <= sxy_next;
        acc_reg    <= acc_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        if (mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        // A side that is short of history reports a zero rate.
        if (ok_wr) begin
            if (side_reg) begin
                hot_ok_reg <= ok_val;
                if (!ok_val) begin
                    hot_rate_reg <= '0;
                end
            end else begin
                cold_ok_reg <= ok_val;
                if (!ok_val) begin
                    cold_rate_reg <= '0;
                end
            end
        end
        if (rate_wr) begin
            if (side_reg) begin
                hot_rate_reg <= (state_reg == ST_SCALE) ? '0 : rate_val;
            end else begin
                cold_rate_reg <= (state_reg == ST_SCALE) ? '0 : rate_val;
            end
        end
        if (out_load) begin
            m_cold_rate_reg <= cold_rate_reg;
            m_cold_ok_reg   <= cold_ok_reg;
            m_hot_rate_reg  <= hot_rate_reg;
            m_hot_ok_reg    <= hot_ok_reg;
            m_stable_reg    <= stable;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_cold_rate       = m_cold_rate_reg;
    assign m_cold_rate_valid = m_cold_ok_reg;
    assign m_hot_rate        = m_hot_rate_reg;
    assign m_hot_rate_valid  = m_hot_ok_reg;
    assign m_hot_stable      = m_stable_reg;

endmodule

`default_nettype wire

// ===== rtl/core/swse_checker.sv =====
// Port-level checker for the slope estimator, attached to the top level by bind.
// Depends on swse_pkg for the rate width.
`default_nettype none

module swse_checker (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                s_valid,
    input wire logic                                s_ready,
    input wire logic                                m_valid,
    input wire logic                                m_ready,
    input wire logic signed [swse_pkg::RATE_W-1:0]  m_cold_rate,
    input wire logic                                m_cold_rate_valid,
    input wire logic signed [swse_pkg::RATE_W-1:0]  m_hot_rate,
    input wire logic                                m_hot_rate_valid,
    input wire logic                                m_hot_stable
);

    // The block works on one beat at a time: it drops ready right after a beat.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("s_ready stayed high after an accepted beat");

    // A stalled result holds its rates.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cold_rate) && $stable(m_hot_rate))
        else $error("result changed while stalled");

    // Stable needs a valid hot rate.
    a_stable_needs_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hot_stable |-> m_hot_rate_valid)
        else $error("hot_stable without a valid hot rate");

    // Short history gives zero rates.
    a_cold_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_cold_rate_valid |-> m_cold_rate == '0)
        else $error("invalid cold rate is not zero");

    a_hot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hot_rate_valid |-> m_hot_rate == '0)
        else $error("invalid hot rate is not zero");

endmodule

bind sliding_window_slope_estimator swse_checker u_swse_checker (.*);

`default_nettype wire

// ===== tb/swse_checker.sv =====
// Result checker for the sliding-window slope estimator.
// Watches the sample, result and register ports, predicts each result beat and compares.
// Depends on swse_pkg for widths, register codes and reset values.

module swse_rate_checker
    import swse_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic signed [TEMP_W-1:0]   s_cold_temp,
    input  logic signed [TEMP_W-1:0]   s_hot_temp,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic signed [RATE_W-1:0]   m_cold_rate,
    input  logic                       m_cold_rate_valid,
    input  logic signed [RATE_W-1:0]   m_hot_rate,
    input  logic                       m_hot_rate_valid,
    input  logic                       m_hot_stable,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic        [APB_AW-1:0]   paddr,
    input  logic        [APB_DW-1:0]   pwdata,
    input  logic        [APB_DW-1:0]   prdata,
    input  logic                       pready,
    output int                         outstanding,
    output int                         mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    // Slope of one side: the rate and whether the history covers the window.
    typedef struct {
        logic signed [RATE_W-1:0] rate;
        logic                     valid;
    } side_rate_t;

    // One predicted result beat.
    typedef struct {
        logic signed [RATE_W-1:0] cold_rate;
        logic                     cold_valid;
        logic signed [RATE_W-1:0] hot_rate;
        logic                     hot_valid;
        logic                     hot_stable;
    } rate_beat_t;

    // Shadow copies of the registers.
    logic [WIN_W-1:0] cold_window;
    logic [WIN_W-1:0] hot_window;
    logic [WIN_W-1:0] stable_min;
    logic [LIM_W-1:0] stable_limit;
    logic [SPM_W-1:0] samples_per_min;

    // Shadow sample ring.
    logic signed [TEMP_W-1:0] cold_ring [HISTORY_DEPTH];
    logic signed [TEMP_W-1:0] hot_ring  [HISTORY_DEPTH];
    int ring_ptr;
    int ring_fill;

    rate_beat_t expected_rates [$];
    int         result_no;

    initial mismatches = 0;
    initial outstanding = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] ERROR: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [RATE_W-1:0] got,
                               input logic [RATE_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s: got %h, expected %h",
                                      result_no, name, got, want));
        end
    endtask

    // Least-squares slope of the newest win samples of one side, scaled to
    // 1/256 degree per minute, truncated toward zero and saturated.
    function automatic side_rate_t slope_of(input int win, input bit hot_side);
        side_rate_t        r;
        longint            n, sx, sy, sxy, sxx, num, den, y;
        longint unsigned   mag, q;
        int                slot;
        r.rate  = '0;
        r.valid = (win <= ring_fill);
        if (!r.valid) begin
            return r;
        end
        n = win;
        sx = 0;
        sy = 0;
        sxy = 0;
        sxx = 0;
        // The oldest sample in the window sits at abscissa zero.
        for (int i = 0; i < win; i++) begin
            slot = (ring_ptr + HISTORY_DEPTH - win + i) % HISTORY_DEPTH;
            y = hot_side ? hot_ring[slot] : cold_ring[slot];
            sx  += i;
            sy  += y;
            sxy += i * y;
            sxx += i * i;
        end
        den = n * sxx - sx * sx;
        if (den <= 0) begin
            return r;
        end
        num = n * sxy - sx * sy;
        mag = (num < 0) ? -num : num;
        q = (mag * 64'd16 * 64'(samples_per_min)) / 64'(den);
        if (num < 0) begin
            if (q > {32'd0, RATE_MIN}) begin
                q = {32'd0, RATE_MIN};
            end
            r.rate = 32'd0 - q[RATE_W-1:0];
        end else begin
            if (q > {32'd0, RATE_MAX}) begin
                q = {32'd0, RATE_MAX};
            end
            r.rate = q[RATE_W-1:0];
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        side_rate_t       cold_side, hot_side;
        rate_beat_t       beat;
        longint           hot_mag;
        logic [APB_DW-1:0] reg_want;
        bit               reg_known;
        if (!aresetn) begin
            cold_window     = COLD_WINDOW_RST;
            hot_window      = HOT_WINDOW_RST;
            stable_min      = STABLE_MIN_RST;
            stable_limit    = STABLE_LIM_RST;
            samples_per_min = SPM_RST;
            ring_ptr        = 0;
            ring_fill       = 0;
            result_no       = 0;
            expected_rates.delete();
            outstanding <= 0;
        end else begin
            // Register writes update the shadow copies; reads are compared against them.
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[APB_AW-1:2])
                        REG_COLD_WINDOW: cold_window     = pwdata[WIN_W-1:0];
                        REG_HOT_WINDOW:  hot_window      = pwdata[WIN_W-1:0];
                        REG_STABLE_MIN:  stable_min      = pwdata[WIN_W-1:0];
                        REG_STABLE_LIM:  stable_limit    = pwdata[LIM_W-1:0];
                        REG_SPM:         samples_per_min = pwdata[SPM_W-1:0];
                        default: ;
                    endcase
                end else begin
                    reg_known = 1'b1;
                    case (paddr[APB_AW-1:2])
                        REG_COLD_WINDOW: reg_want = APB_DW'(cold_window);
                        REG_HOT_WINDOW:  reg_want = APB_DW'(hot_window);
                        REG_STABLE_MIN:  reg_want = APB_DW'(stable_min);
                        REG_STABLE_LIM:  reg_want = APB_DW'(stable_limit);
                        REG_SPM:         reg_want = APB_DW'(samples_per_min);
                        default: begin
                            reg_known = 1'b0;
                            reg_want  = '0;
                        end
                    endcase
                    if (reg_known && prdata !== reg_want) begin
                        report_mismatch($sformatf("register read at %h: got %h, expected %h",
                                                  paddr, prdata, reg_want));
                    end
                end
            end

            // A result beat is matched against the oldest prediction.
            if (m_valid && m_ready) begin
                if (expected_rates.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              result_no));
                end else begin
                    beat = expected_rates.pop_front();
                    check_field("cold_rate", m_cold_rate, beat.cold_rate);
                    check_field("cold_rate_valid", m_cold_rate_valid, beat.cold_valid);
                    check_field("hot_rate", m_hot_rate, beat.hot_rate);
                    check_field("hot_rate_valid", m_hot_rate_valid, beat.hot_valid);
                    check_field("hot_stable", m_hot_stable, beat.hot_stable);
                end
                result_no++;
            end

            // A sample beat goes into the ring, then both slopes are predicted.
            if (s_valid && s_ready) begin
                cold_ring[ring_ptr] = s_cold_temp;
                hot_ring[ring_ptr]  = s_hot_temp;
                ring_ptr = (ring_ptr + 1) % HISTORY_DEPTH;
                if (ring_fill < HISTORY_DEPTH) begin
                    ring_fill++;
                end
                cold_side = slope_of(cold_window, 1'b0);
                hot_side  = slope_of(hot_window, 1'b1);
                hot_mag = hot_side.rate;
                if (hot_mag < 0) begin
                    hot_mag = -hot_mag;
                end
                beat.cold_rate  = cold_side.rate;
                beat.cold_valid = cold_side.valid;
                beat.hot_rate   = hot_side.rate;
                beat.hot_valid  = hot_side.valid;
                beat.hot_stable = (ring_fill >= int'(stable_min)) && hot_side.valid &&
                                  (hot_mag <= longint'(stable_limit));
                expected_rates.push_back(beat);
            end

            outstanding <= expected_rates.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the testbench for the sliding-window slope estimator.
// Drives samples, results backpressure and register writes; swse_rate_checker does the checking.
// Depends on swse_pkg, the estimator RTL and tb/swse_checker.sv.

module testbench;
    import swse_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TEMP_HI         = (1 << (TEMP_W - 1)) - 1;
    localparam int TEMP_LO         = -(1 << (TEMP_W - 1));
    localparam int RESET_CYCLES    = 8;
    localparam int SETTLE_CYCLES   = 16;
    localparam int DRAIN_CYCLES    = 500;
    localparam int CYCLE_LIMIT     = 4_000_000;
    localparam int RAND_PHASES     = 14;
    localparam int PHASE_ITEMS     = 100;
    localparam logic [REGIX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [REGIX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                     aclk    = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic signed [TEMP_W-1:0] s_cold_temp = '0;
    logic signed [TEMP_W-1:0] s_hot_temp  = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [RATE_W-1:0] m_cold_rate;
    logic                     m_cold_rate_valid;
    logic signed [RATE_W-1:0] m_hot_rate;
    logic                     m_hot_rate_valid;
    logic                     m_hot_stable;
    logic                     psel    = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite  = 1'b0;
    logic [APB_AW-1:0]        paddr   = '0;
    logic [APB_DW-1:0]        pwdata  = '0;
    logic [APB_DW-1:0]        prdata;
    logic                     pready;

    int outstanding;
    int mismatches;
    bit quiet = 1'b0;
    int stall_left = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    sliding_window_slope_estimator u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_cold_temp       (s_cold_temp),
        .s_hot_temp        (s_hot_temp),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_cold_rate       (m_cold_rate),
        .m_cold_rate_valid (m_cold_rate_valid),
        .m_hot_rate        (m_hot_rate),
        .m_hot_rate_valid  (m_hot_rate_valid),
        .m_hot_stable      (m_hot_stable),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    swse_rate_checker u_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_cold_temp       (s_cold_temp),
        .s_hot_temp        (s_hot_temp),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_cold_rate       (m_cold_rate),
        .m_cold_rate_valid (m_cold_rate_valid),
        .m_hot_rate        (m_hot_rate),
        .m_hot_rate_valid  (m_hot_rate_valid),
        .m_hot_stable      (m_hot_stable),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .outstanding       (outstanding),
        .mismatches        (mismatches)
    );

    // Result side backpressure: random stall bursts.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 11);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // One register transfer: setup phase, access phase, then back to idle.
    task automatic apb_access(input bit wr, input logic [REGIX_W-1:0] idx,
                              input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic read_back();
        apb_access(1'b0, REG_COLD_WINDOW, '0);
        apb_access(1'b0, REG_HOT_WINDOW, '0);
        apb_access(1'b0, REG_STABLE_MIN, '0);
        apb_access(1'b0, REG_STABLE_LIM, '0);
        apb_access(1'b0, REG_SPM, '0);
    endtask

    // Stop sending and wait until every predicted result has been taken.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // Reprogram all registers while the block is idle; unused upper bits carry junk at times.
    task automatic program_regs(input logic [WIN_W-1:0] cw, input logic [WIN_W-1:0] hw,
                                input logic [WIN_W-1:0] smin, input logic [LIM_W-1:0] lim,
                                input logic [SPM_W-1:0] spm);
        logic [APB_DW-1:0] junk;
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        junk = $urandom_range(0, 1) ? $urandom() : '0;
        apb_access(1'b1, REG_COLD_WINDOW, {junk[APB_DW-1:WIN_W], cw});
        apb_access(1'b1, REG_HOT_WINDOW, {junk[APB_DW-1:WIN_W], hw});
        apb_access(1'b1, REG_STABLE_MIN, {junk[APB_DW-1:WIN_W], smin});
        apb_access(1'b1, REG_STABLE_LIM, {junk[APB_DW-1:LIM_W], lim});
        apb_access(1'b1, REG_SPM, {junk[APB_DW-1:SPM_W], spm});
        read_back();
    endtask

    // Send one sample beat, sometimes after an idle burst; valid stays up afterwards.
    task automatic push_sample(input logic signed [TEMP_W-1:0] c,
                               input logic signed [TEMP_W-1:0] h);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            // Half of the gaps start once the block is back in idle.
            if ($urandom_range(0, 1) == 1) begin
                do @(posedge aclk); while (!s_ready);
            end
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_cold_temp <= c;
        s_hot_temp  <= h;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic logic [WIN_W-1:0] pick_window();
        case ($urandom_range(0, 7))
            0:       return WIN_W'($urandom_range(0, 1));
            1:       return WIN_W'(HISTORY_DEPTH_DEF);
            2:       return WIN_W'($urandom_range(HISTORY_DEPTH_DEF + 1, (1 << WIN_W) - 1));
            default: return WIN_W'($urandom_range(2, HISTORY_DEPTH_DEF));
        endcase
    endfunction

    function automatic int clamp12(input int v);
        return (v > TEMP_HI) ? TEMP_HI : ((v < TEMP_LO) ? TEMP_LO : v);
    endfunction

    // Watchdog on the whole run.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("FAIL");
        $finish;
    end

    initial begin
        int               cold_lvl, hot_lvl, c_drift, h_drift, amp, kind;
        bit               calm;
        logic [WIN_W-1:0] smin;
        logic [LIM_W-1:0] lim;
        logic [SPM_W-1:0] spm;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        read_back();

        // Short history under the reset settings, with the temperature extremes.
        push_sample(TEMP_W'(TEMP_HI), TEMP_W'(TEMP_LO));
        push_sample(TEMP_W'(TEMP_LO), TEMP_W'(TEMP_HI));
        push_sample('0, '0);

        // Windows of zero and one give valid zero rates; a zero limit still counts as stable.
        program_regs(0, 1, 0, 0, 60);
        push_sample(1, -1);
        push_sample(-1, 1);

        // Full-swing steps at 60000 samples per minute saturate in both directions.
        program_regs(2, 3, 5, 16'hFFFF, 60000);
        push_sample(TEMP_W'(TEMP_HI), TEMP_W'(TEMP_LO));
        push_sample(TEMP_W'(TEMP_LO), TEMP_W'(TEMP_HI));
        push_sample(TEMP_W'(TEMP_HI), TEMP_W'(TEMP_LO));
        push_sample(TEMP_W'(TEMP_LO), TEMP_W'(TEMP_HI));
        push_sample(100, 200);
        push_sample(-5, 7);

        // Windows beyond the history, and writes to unused addresses that must change nothing.
        program_regs(HISTORY_DEPTH_DEF, (1 << WIN_W) - 1, (1 << WIN_W) - 1, 16'hFFFF, 0);
        apb_access(1'b1, REG_SPARE_LO, '1);
        apb_access(1'b1, REG_SPARE_HI, '1);
        read_back();
        push_sample(300, -300);
        push_sample(-700, 700);
        push_sample(TEMP_W'(TEMP_HI), TEMP_W'(TEMP_HI));

        // A zero sampling rate forces zero rates on valid windows.
        program_regs(4, 4, 0, 256, 0);
        push_sample(12, -40);
        push_sample(900, 33);
        push_sample(-1000, 2000);

        // Random phases: slowly drifting plate temperatures with noise and occasional jumps.
        cold_lvl = 0;
        hot_lvl  = 0;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case ($urandom_range(0, 9))
                0:       smin = '0;
                1:       smin = '1;
                default: smin = WIN_W'($urandom_range(0, HISTORY_DEPTH_DEF));
            endcase
            case ($urandom_range(0, 9))
                0:       lim = '0;
                1:       lim = '1;
                2:       lim = LIM_W'($urandom());
                default: lim = LIM_W'($urandom_range(0, 4096));
            endcase
            case ($urandom_range(0, 9))
                0:       spm = '0;
                1:       spm = 1;
                2:       spm = 60000;
                3:       spm = '1;
                default: spm = SPM_W'($urandom_range(1, 60000));
            endcase
            program_regs(pick_window(), pick_window(), smin, lim, spm);

            // The last phase runs with no idling on either side.
            quiet   = (ph == RAND_PHASES - 1);
            calm    = ($urandom_range(0, 2) == 0);
            c_drift = calm ? 0 : int'($urandom_range(0, 80)) - 40;
            h_drift = calm ? 0 : int'($urandom_range(0, 80)) - 40;
            amp     = calm ? int'($urandom_range(0, 1)) : int'($urandom_range(0, 24));
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                kind = calm ? 9 : int'($urandom_range(0, 9));
                case (kind)
                    0: begin
                        cold_lvl = int'($urandom_range(0, 4095)) + TEMP_LO;
                        hot_lvl  = int'($urandom_range(0, 4095)) + TEMP_LO;
                    end
                    1: begin
                        cold_lvl = $urandom_range(0, 1) ? TEMP_HI : TEMP_LO;
                        hot_lvl  = $urandom_range(0, 1) ? TEMP_HI : TEMP_LO;
                    end
                    default: begin
                        cold_lvl = clamp12(cold_lvl + c_drift +
                                           int'($urandom_range(0, 2 * amp)) - amp);
                        hot_lvl  = clamp12(hot_lvl + h_drift +
                                           int'($urandom_range(0, 2 * amp)) - amp);
                    end
                endcase
                push_sample(TEMP_W'(cold_lvl), TEMP_W'(hot_lvl));
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/swse_pkg.sv
rtl/core/swse_ram.sv
rtl/core/swse_div.sv
rtl/core/sliding_window_slope_estimator.sv
rtl/core/swse_checker.sv
tb/swse_checker.sv
tb/testbench.sv
